FILE: design/heartbeat_offline_monitor_core_assert.svh
// ----------------------------------------------------------------------------
// heartbeat_offline_monitor_core_assert.svh
// Assertion macros for the heartbeat monitor; empty bodies in synthesis.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_OFFLINE_MONITOR_CORE_ASSERT_SVH
`define HEARTBEAT_OFFLINE_MONITOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HOM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define HOM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/hom_pkg.sv
// ----------------------------------------------------------------------------
// hom_pkg
// Shared types and constants of the heartbeat offline monitor.
// ----------------------------------------------------------------------------
package hom_pkg;

  // widest device count the output masks carry
  localparam int MAX_DEV  = 4;
  localparam int DEV_BITS = 2;
  localparam int THR_BITS = 16;
  localparam int PRI_BITS = 8;

  typedef logic [DEV_BITS-1:0] dev_t;
  typedef logic [MAX_DEV-1:0]  mask_t;

  // input word modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_BEAT = 1'b1;

  // flag bit positions in a device entry, time stamp above them
  localparam int FLG_LOST  = 0;
  localparam int FLG_ERR   = 1;
  localparam int FLG_FAULT = 2;
  localparam int FLG_BITS  = 3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_OFFLINE = 2'd0,
    CFG_ONLINE  = 2'd1,
    CFG_PRIO    = 2'd2,
    CFG_ENABLE  = 2'd3
  } cfg_idx_t;

  localparam int CFG_DATA_BITS = 64;

  localparam logic [63:0] OFFLINE_RST = 64'd171801313300;
  localparam logic [63:0] ONLINE_RST  = 64'd0;
  localparam logic [31:0] PRIO_RST    = 32'd658191;
  localparam logic [3:0]  ENABLE_RST  = 4'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic mode;
    dev_t device;
    logic data_fault;
  } in_word_t;

  typedef struct packed {
    mask_t lost_mask;
    mask_t error_mask;
    logic  any_lost;
    dev_t  top_device;
    mask_t newly_lost_mask;
  } out_word_t;

  // per-device evaluation control
  typedef struct packed {
    logic beat;
    logic hit;
    logic data_fault;
    logic enabled;
  } eval_ctl_t;

  // per-device evaluation status
  typedef struct packed {
    logic over;
    logic newly;
  } eval_res_t;

endpackage

FILE: design/hom_dev_ram.sv
// ----------------------------------------------------------------------------
// hom_dev_ram
// Device entry memory: one write and one registered read port, with a valid
// bit per entry so that an unwritten entry reads as its reset word.
// ----------------------------------------------------------------------------
module hom_dev_ram #(
  parameter int                 DEPTH    = 4,
  parameter int                 IDX_W    = 2,
  parameter int                 WIDTH    = 35,
  parameter logic [WIDTH-1:0]   RST_WORD = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_word_r;
  logic             rd_vld_r;

  // storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rd_word_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : RST_WORD;

endmodule

FILE: design/hom_eval.sv
// ----------------------------------------------------------------------------
// hom_eval
// Update of one device entry for a beat or for one step of a tick scan.
// ----------------------------------------------------------------------------
module hom_eval #(
  parameter int TIME_BITS = 32
) (
  input  hom_pkg::eval_ctl_t                          ctl,
  input  logic [TIME_BITS-1:0]                        now_tick,
  input  logic [TIME_BITS+hom_pkg::FLG_BITS-1:0]      entry_in,
  input  logic [hom_pkg::THR_BITS-1:0]                off_thr,
  input  logic [hom_pkg::THR_BITS-1:0]                on_thr,
  output logic [TIME_BITS+hom_pkg::FLG_BITS-1:0]      entry_out,
  output hom_pkg::eval_res_t                          res
);

  logic [TIME_BITS-1:0] last;
  logic [TIME_BITS-1:0] elapsed;
  logic                 lost;
  logic                 err;
  logic                 fault;

  assign elapsed = now_tick - entry_in[TIME_BITS+hom_pkg::FLG_BITS-1:hom_pkg::FLG_BITS];

  always_comb begin
    last      = entry_in[TIME_BITS+hom_pkg::FLG_BITS-1:hom_pkg::FLG_BITS];
    lost      = entry_in[hom_pkg::FLG_LOST];
    err       = entry_in[hom_pkg::FLG_ERR];
    fault     = entry_in[hom_pkg::FLG_FAULT];
    res.over  = 1'b0;
    res.newly = 1'b0;
    if (ctl.beat) begin
      // heartbeat: restamp, clear lost, track data fault
      if (ctl.hit) begin
        last = now_tick;
        lost = 1'b0;
        if (ctl.data_fault) begin
          err   = 1'b1;
          fault = 1'b1;
        end else begin
          fault = 1'b0;
        end
      end
    end else if (ctl.enabled) begin
      // scan step
      if (elapsed > TIME_BITS'(off_thr)) begin
        res.over = 1'b1;
        if (!err) begin
          lost      = 1'b1;
          err       = 1'b1;
          res.newly = 1'b1;
        end
      end else if (elapsed < TIME_BITS'(on_thr)) begin
        lost = 1'b0;
        err  = 1'b1;
      end else begin
        lost = 1'b0;
        err  = fault;
      end
    end
    entry_out = {last, fault, err, lost};
  end

endmodule

FILE: design/heartbeat_offline_monitor_core.sv
// ----------------------------------------------------------------------------
// heartbeat_offline_monitor_core
// Multi-device heartbeat watchdog built around a device entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken on in_word when start is high and busy is low. mode 0
//   advances the tick counter and scans every enabled device; mode 1 records
//   a heartbeat (and its data check) for in_word.device.
//   Every word yields one result word on out_word, shown for exactly one
//   cycle with out_valid high. The receiver cannot stall it.
//   Each word sweeps all device entries of the memory in state READ, one
//   read per cycle, with the write-back in the cycle after its read; then
//   state DRAIN sets the registered out_valid. busy drops in the cycle that
//   shows the result, so a new word can be taken in that cycle.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at once
//   (0 offline thresholds, 1 online thresholds, 2 priorities, 3 enable
//   mask); write only while no word is in flight.
//   Reset: synchronous, active low. Registers take their reset values and
//   the entry valid bits clear, so every device reads as lost, faulted, not
//   in error, last beat at tick 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "heartbeat_offline_monitor_core_assert.svh"

module heartbeat_offline_monitor_core #(
  parameter int NUM_DEVICES = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  hom_pkg::in_word_t                     in_word,
  output logic                                  out_valid,
  output hom_pkg::out_word_t                    out_word,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [hom_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

  localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int CNT_W = $clog2(NUM_DEVICES + 1);
  localparam int ENT_W = TIME_BITS + hom_pkg::FLG_BITS;
  localparam logic [ENT_W-1:0] RST_WORD =
    ENT_W'((1 << hom_pkg::FLG_LOST) | (1 << hom_pkg::FLG_FAULT));

  hom_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                rv_r;
  logic [IDX_W-1:0]    wr_idx_r;
  hom_pkg::in_word_t   itm_r;
  logic [TIME_BITS-1:0] now_r;

  logic [63:0]         cfg_off_r;
  logic [63:0]         cfg_on_r;
  logic [31:0]         cfg_pri_r;
  logic [3:0]          cfg_en_r;

  hom_pkg::mask_t      acc_lost_r, acc_lost_nxt;
  hom_pkg::mask_t      acc_err_r, acc_err_nxt;
  hom_pkg::mask_t      acc_new_r, acc_new_nxt;
  logic                acc_any_r, acc_any_nxt;
  logic [hom_pkg::PRI_BITS-1:0] acc_best_r, acc_best_nxt;
  logic [IDX_W-1:0]    acc_top_r, acc_top_nxt;
  logic                sum_any_r;
  hom_pkg::dev_t       sum_top_r;

  logic                out_valid_r;
  hom_pkg::out_word_t  out_word_r;

  logic                accept;
  logic                mem_re;
  logic                mem_we;
  logic [IDX_W-1:0]    rd_addr;
  logic [ENT_W-1:0]    rd_data;
  logic [ENT_W-1:0]    wr_data;
  hom_pkg::dev_t       dev_sel;
  hom_pkg::eval_ctl_t  ev_ctl;
  hom_pkg::eval_res_t  ev_res;
  logic [hom_pkg::PRI_BITS-1:0] cur_pri;

  assign accept  = start && (state_r == hom_pkg::ST_IDLE);
  assign rd_addr = rd_cnt_r[IDX_W-1:0];
  assign dev_sel = hom_pkg::dev_t'(wr_idx_r);
  assign cur_pri = cfg_pri_r[dev_sel*hom_pkg::PRI_BITS +: hom_pkg::PRI_BITS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_off_r <= hom_pkg::OFFLINE_RST;
      cfg_on_r  <= hom_pkg::ONLINE_RST;
      cfg_pri_r <= hom_pkg::PRIO_RST;
      cfg_en_r  <= hom_pkg::ENABLE_RST;
    end else if (cfg_we) begin
      case (hom_pkg::cfg_idx_t'(cfg_index))
        hom_pkg::CFG_OFFLINE: cfg_off_r <= cfg_wdata;
        hom_pkg::CFG_ONLINE:  cfg_on_r  <= cfg_wdata;
        hom_pkg::CFG_PRIO:    cfg_pri_r <= cfg_wdata[31:0];
        hom_pkg::CFG_ENABLE:  cfg_en_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hom_pkg::ST_IDLE: begin
        if (start) state_nxt = hom_pkg::ST_READ;
      end
      hom_pkg::ST_READ: begin
        if (rd_cnt_r == CNT_W'(NUM_DEVICES - 1)) state_nxt = hom_pkg::ST_DRAIN;
      end
      hom_pkg::ST_DRAIN: state_nxt = hom_pkg::ST_IDLE;
      default:           state_nxt = hom_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mem_re     = 1'b0;
    rd_cnt_nxt = rd_cnt_r;
    case (state_r)
      hom_pkg::ST_IDLE: rd_cnt_nxt = '0;
      hom_pkg::ST_READ: begin
        mem_re     = 1'b1;
        rd_cnt_nxt = rd_cnt_r + 1'b1;
      end
      hom_pkg::ST_DRAIN: rd_cnt_nxt = '0;
      default:           rd_cnt_nxt = '0;
    endcase
  end

  // write-back follows the read in the next cycle; addresses never coincide
  assign mem_we = rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hom_pkg::ST_IDLE;
      rd_cnt_r <= '0;
      rv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      rv_r     <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) wr_idx_r <= rd_addr;
  end

  // capture word, advance tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else if (accept && (in_word.mode == hom_pkg::MODE_TICK)) begin
      now_r <= now_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) itm_r <= in_word;
  end

  hom_dev_ram #(
    .DEPTH    (NUM_DEVICES),
    .IDX_W    (IDX_W),
    .WIDTH    (ENT_W),
    .RST_WORD (RST_WORD)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (mem_we),
    .wr_addr (wr_idx_r),
    .wr_data (wr_data),
    .re      (mem_re),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // per-device evaluation control
  always_comb begin
    ev_ctl.beat       = (itm_r.mode == hom_pkg::MODE_BEAT);
    ev_ctl.hit        = (itm_r.device == dev_sel);
    ev_ctl.data_fault = itm_r.data_fault;
    ev_ctl.enabled    = cfg_en_r[dev_sel];
  end

  hom_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .ctl       (ev_ctl),
    .now_tick  (now_r),
    .entry_in  (rd_data),
    .off_thr   (cfg_off_r[dev_sel*hom_pkg::THR_BITS +: hom_pkg::THR_BITS]),
    .on_thr    (cfg_on_r[dev_sel*hom_pkg::THR_BITS +: hom_pkg::THR_BITS]),
    .entry_out (wr_data),
    .res       (ev_res)
  );

  // accumulate masks and the priority pick
  always_comb begin
    acc_lost_nxt = acc_lost_r;
    acc_err_nxt  = acc_err_r;
    acc_new_nxt  = acc_new_r;
    acc_any_nxt  = acc_any_r;
    acc_best_nxt = acc_best_r;
    acc_top_nxt  = acc_top_r;
    if (rv_r) begin
      acc_lost_nxt[dev_sel] = wr_data[hom_pkg::FLG_LOST];
      acc_err_nxt[dev_sel]  = wr_data[hom_pkg::FLG_ERR];
      acc_new_nxt[dev_sel]  = ev_res.newly;
      if (ev_res.over) begin
        if (!acc_any_r || (cur_pri > acc_best_r)) begin
          acc_best_nxt = cur_pri;
          acc_top_nxt  = wr_idx_r;
        end
        acc_any_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_lost_r <= '0;
      acc_err_r  <= '0;
      acc_new_r  <= '0;
      acc_any_r  <= 1'b0;
      acc_best_r <= '0;
      acc_top_r  <= '0;
    end else begin
      acc_lost_r <= acc_lost_nxt;
      acc_err_r  <= acc_err_nxt;
      acc_new_r  <= acc_new_nxt;
      acc_any_r  <= acc_any_nxt;
      acc_best_r <= acc_best_nxt;
      acc_top_r  <= acc_top_nxt;
    end
  end

  // scan summary, committed at the end of a tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_any_r <= 1'b0;
      sum_top_r <= '0;
    end else if ((state_r == hom_pkg::ST_DRAIN) && (itm_r.mode == hom_pkg::MODE_TICK)) begin
      sum_any_r <= acc_any_nxt;
      sum_top_r <= hom_pkg::dev_t'(acc_top_nxt);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == hom_pkg::ST_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hom_pkg::ST_DRAIN) begin
      out_word_r.lost_mask       <= acc_lost_nxt;
      out_word_r.error_mask      <= acc_err_nxt;
      out_word_r.newly_lost_mask <= acc_new_nxt;
      if (itm_r.mode == hom_pkg::MODE_TICK) begin
        out_word_r.any_lost   <= acc_any_nxt;
        out_word_r.top_device <= hom_pkg::dev_t'(acc_top_nxt);
      end else begin
        out_word_r.any_lost   <= sum_any_r;
        out_word_r.top_device <= sum_top_r;
      end
    end
  end

  assign busy      = (state_r != hom_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  `HOM_ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_we && mem_re, rd_addr != wr_idx_r, "read and write-back hit the same entry")
  `HOM_ASSERT_IMP(a_out_after_drain, clk, rst_n, out_valid, $past(state_r == hom_pkg::ST_DRAIN), "result without a finished sweep")
  `HOM_ASSERT_NXT(a_accept_starts, clk, rst_n, start && !busy, state_r == hom_pkg::ST_READ, "accepted word did not start a sweep")
  `HOM_ASSERT_IMP(a_drain_has_write, clk, rst_n, state_r == hom_pkg::ST_DRAIN, rv_r && !mem_re, "last write-back missing at drain")

endmodule
